// ===== rtl/smcp_pkg.sv =====
// Shared types, character codes and helpers for the monitor command parser.
`timescale 1ns / 1ps

package smcp_pkg;

    // Bytes accepted on one write line before the line is rejected.
    localparam int MAX_LINE_BYTES = 16;

    // Characters that steer the parser.
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_D  = 8'h44;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_UC_G  = 8'h47;

    // What the address being collected is for.
    typedef enum logic [1:0] {
        TGT_WRITE = 2'd0,
        TGT_DUMP  = 2'd1,
        TGT_JUMP  = 2'd2
    } target_t;

    // One result beat.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_char;
        logic        write_valid;
        logic [31:0] write_addr;
        logic [7:0]  write_data;
        logic        dump_valid;
        logic [31:0] dump_addr;
        logic [31:0] dump_len;
        logic        jump_valid;
        logic [31:0] jump_addr;
    } result_t;

    // Lower-case hex digit to its value; anything else reads as 0xF.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h0F;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
            end
            else if (c >= CH_LC_A && c <= CH_LC_F)
            begin
                d = c - CH_LC_A + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage

// ===== rtl/smcp_out_stage.sv =====
// Output register for result beats, with valid/stall handshake.
`timescale 1ns / 1ps

module smcp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  smcp_pkg::result_t res_in,
    input  logic             out_stall,
    output logic             out_valid,
    output smcp_pkg::result_t res_out
);
    import smcp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Valid flag: set on a load, cleared once the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled; load must only happen when the slot is free, and this stage does not enforce it.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== rtl/serial_monitor_command_parser.sv =====
// Top level of the monitor command parser: line parsing state machine and result stage.
`timescale 1ns / 1ps

//  channel | beat contents                              | handshake
//  --------+--------------------------------------------+---------------------
//  in      | rx_char                                    | in_valid / in_stall
//  out     | tx, write, dump and jump fields            | out_valid / out_stall
//
// Each character beat produces exactly one result beat, registered in the cycle after it is accepted.
// A new character is taken every cycle unless the output register is full
// and stalled; in_stall follows out_stall only while a result is waiting.
// Reset puts the parser idle with echo off and clears the accumulators.
// After a go command the parser halts and returns all-zero results.

module serial_monitor_command_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_char,
    output logic        write_valid,
    output logic [31:0] write_addr,
    output logic [7:0]  write_data,
    output logic        dump_valid,
    output logic [31:0] dump_addr,
    output logic [31:0] dump_len,
    output logic        jump_valid,
    output logic [31:0] jump_addr
);
    import smcp_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE,
        M_CMD,
        M_ZERO,
        M_ADDR,
        M_BYTE_HI,
        M_BYTE_LO,
        M_DUMP_LEN,
        M_ERROR,
        M_HALT
    } mode_t;

    mode_t       mode_reg,   mode_next;
    target_t     target_reg, target_next;
    logic [31:0] addr_reg,   addr_next;
    logic [31:0] count_reg,  count_next;
    logic [3:0]  hi_reg,     hi_next;
    logic        echo_reg,   echo_next;

    logic        accept;
    logic [3:0]  nib;
    result_t     res;
    result_t     res_q;

    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign nib      = nibble_of(rx_char);

    // Next state and result for the character on the input port.
    always_comb
    begin
        mode_next   = mode_reg;
        target_next = target_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        hi_next     = hi_reg;
        echo_next   = echo_reg;
        res         = '0;

        if (mode_reg != M_HALT)
        begin
            if (echo_reg)
            begin
                res.tx_valid = 1'b1;
                res.tx_char  = rx_char;
            end
            else if (rx_char == CH_NL)
            begin
                res.tx_valid = 1'b1;
                res.tx_char  = CH_DOT;
            end
        end

        case (mode_reg)
            M_IDLE:
            begin
                if (rx_char == CH_SPACE)
                begin
                    mode_next = M_IDLE;
                end
                else if (rx_char == CH_ZERO)
                begin
                    mode_next   = M_ZERO;
                    target_next = TGT_WRITE;
                end
                else if (rx_char == CH_UC_E)
                begin
                    echo_next = ~echo_reg;
                    mode_next = M_ERROR;
                end
                else if (rx_char == CH_UC_D)
                begin
                    target_next = TGT_DUMP;
                    mode_next   = M_CMD;
                end
                else if (rx_char == CH_UC_G)
                begin
                    target_next = TGT_JUMP;
                    mode_next   = M_CMD;
                end
                else if (rx_char != CH_NL)
                begin
                    mode_next = M_ERROR;
                end
            end
            M_CMD:
            begin
                if (rx_char == CH_ZERO)
                begin
                    mode_next = M_ZERO;
                end
                else if (rx_char == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_ZERO:
            begin
                if (rx_char == CH_LC_X)
                begin
                    mode_next = M_ADDR;
                    addr_next = '0;
                end
                else if (rx_char == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    mode_next = M_ERROR;
                end
            end
            M_ADDR:
            begin
                if (rx_char == CH_SPACE || rx_char == CH_NL)
                begin
                    count_next = '0;
                    case (target_reg)
                        TGT_JUMP:
                        begin
                            res.jump_valid = 1'b1;
                            res.jump_addr  = addr_reg;
                            mode_next      = M_HALT;
                        end
                        TGT_DUMP:
                        begin
                            mode_next = M_DUMP_LEN;
                        end
                        default:
                        begin
                            mode_next = M_BYTE_HI;
                        end
                    endcase
                end
                else
                begin
                    addr_next = {addr_reg[27:0], nib};
                end
            end
            M_BYTE_HI:
            begin
                if (rx_char == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
                else if (rx_char == CH_SPACE)
                begin
                    mode_next = M_BYTE_HI;
                end
                else if (count_reg >= 32'(MAX_LINE_BYTES))
                begin
                    mode_next = M_ERROR;
                end
                else
                begin
                    hi_next   = nib;
                    mode_next = M_BYTE_LO;
                end
            end
            M_BYTE_LO:
            begin
                if (rx_char == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    res.write_valid = 1'b1;
                    res.write_addr  = addr_reg + count_reg;
                    res.write_data  = {hi_reg, nib};
                    count_next      = count_reg + 32'd1;
                    mode_next       = M_BYTE_HI;
                end
            end
            M_DUMP_LEN:
            begin
                if (rx_char == CH_NL)
                begin
                    res.dump_valid = 1'b1;
                    res.dump_addr  = addr_reg;
                    res.dump_len   = count_reg;
                    mode_next      = M_IDLE;
                end
                else
                begin
                    count_next = {count_reg[27:0], nib};
                end
            end
            M_ERROR:
            begin
                if (rx_char == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_HALT:
            begin
                mode_next = M_HALT;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
    end

    // Parser state advances once per accepted character beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            target_reg <= TGT_WRITE;
            addr_reg   <= '0;
            count_reg  <= '0;
            hi_reg     <= '0;
            echo_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
            hi_reg     <= hi_next;
            echo_reg   <= echo_next;
        end
    end

    // Result register toward the output channel.
    smcp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign tx_valid    = res_q.tx_valid;
    assign tx_char     = res_q.tx_char;
    assign write_valid = res_q.write_valid;
    assign write_addr  = res_q.write_addr;
    assign write_data  = res_q.write_data;
    assign dump_valid  = res_q.dump_valid;
    assign dump_addr   = res_q.dump_addr;
    assign dump_len    = res_q.dump_len;
    assign jump_valid  = res_q.jump_valid;
    assign jump_addr   = res_q.jump_addr;

endmodule
